### sv/sbim_pkg.sv
// shared widths, register indexes and defaults for the interest matching block
package sbim_pkg;

	localparam int ID_W = 9;
	localparam int NS_W = 7;
	localparam int NU_W = 9;
	localparam int CNT_W = NU_W + 1;
	localparam int SET_W = 64;
	localparam int UIDX_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 9;

	localparam int MAX_SUBSCR_DEF = 64;
	localparam int MAX_UPDATE_DEF = 256;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUBSCR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_UPDATE = 1'b1;

	localparam logic [NS_W-1:0] NUM_SUBSCR_RST = 7'd64;
	localparam logic [NU_W-1:0] NUM_UPDATE_RST = 9'd256;

endpackage

### sv/sbim_row_mem.sv
// per-update row storage with one write port and one registered read port
module sbim_row_mem #(
	parameter int DEPTH = sbim_pkg::MAX_UPDATE_DEF,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [sbim_pkg::SET_W-1:0]   wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [sbim_pkg::SET_W-1:0]   rdata
);

	logic [sbim_pkg::SET_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/sort_based_interest_matching_unit.sv
// top level of the sort-based interest matching unit
//
// Takes one sorted extent endpoint per transaction on the input channel
// (in_valid / in_stall) and returns, for each update upper endpoint, one
// transaction on the output channel (out_valid / out_stall) carrying the
// update index and its subscription match row, ANDed over all dimension
// passes so far. Other endpoints produce no output transaction.
// Configuration (num_subscr, num_update) is written through cfg_we / cfg_index /
// cfg_data; the user must write it only while the block is idle, as the block does not enforce this.
// An accepted endpoint passes an input register stage, then a stage holding
// the registered snapshot and row memory reads, then the output register.
// One endpoint is accepted every cycle while in_stall is low; the limit is
// the single read and write port of each row memory.
// Reset clears the pipeline, empties the before set, fills the after set and
// zeroes the endpoint counter, so endpoints are ignored until a pass_start.
// The row memories are not cleared. When the output register holds a
// result under out_stall, the pipeline keeps moving until a second result
// reaches the last stage; then in_stall rises until out_stall drops.
module sort_based_interest_matching_unit #(
	parameter int MAX_SUBSCR = sbim_pkg::MAX_SUBSCR_DEF,
	parameter int MAX_UPDATE = sbim_pkg::MAX_UPDATE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sbim_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbim_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sbim_pkg::ID_W-1:0]         endpoint_id,
	input  logic                              is_lower,
	input  logic                              pass_start,
	input  logic                              first_dimension,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sbim_pkg::UIDX_W-1:0]       update_index,
	output logic [sbim_pkg::SET_W-1:0]        match_row
);

	localparam int AW = (MAX_UPDATE > 1) ? $clog2(MAX_UPDATE) : 1;
	localparam int ID_W = sbim_pkg::ID_W;
	localparam int NS_W = sbim_pkg::NS_W;
	localparam int NU_W = sbim_pkg::NU_W;
	localparam int CNT_W = sbim_pkg::CNT_W;
	localparam int SET_W = sbim_pkg::SET_W;
	localparam int UIDX_W = sbim_pkg::UIDX_W;

	logic [NS_W-1:0]  num_subscr_q;
	logic [NU_W-1:0]  num_update_q;

	logic [SET_W-1:0] before_q;
	logic [SET_W-1:0] after_q;
	logic [CNT_W-1:0] left_q;

	logic             valid_s1;
	logic [ID_W-1:0]  id_s1;
	logic             lower_s1;
	logic             start_s1;
	logic             first_s1;

	logic              res_s2;
	logic [AW-1:0]     addr_s2;
	logic [UIDX_W-1:0] uidx_s2;
	logic              first_s2;
	logic [SET_W-1:0]  open_s2;
	logic              fwd_s2;
	logic [SET_W-1:0]  wr_row_q;

	logic              out_valid_q;
	logic [UIDX_W-1:0] out_uidx_q;
	logic [SET_W-1:0]  out_row_q;

	logic             adv;
	logic [NS_W-1:0]  ns_e;
	logic [NU_W-1:0]  nu_e;
	logic [SET_W-1:0] mask;
	logic [SET_W-1:0] bef_e;
	logic [SET_W-1:0] aft_e;
	logic [CNT_W-1:0] cnt_e;
	logic [SET_W-1:0] bef_n;
	logic [SET_W-1:0] aft_n;
	logic [CNT_W-1:0] cnt_n;
	logic [ID_W-1:0]  u;
	logic [AW-1:0]    addr_s1;
	logic             snap_we;
	logic             upper_hit;

	logic [SET_W-1:0] snap_rd;
	logic [SET_W-1:0] acc_rd;
	logic [SET_W-1:0] acc_val;
	logic [SET_W-1:0] row_s2;

	assign adv = !(res_s2 && out_valid_q && out_stall);
	assign in_stall = !adv;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_subscr_q <= sbim_pkg::NUM_SUBSCR_RST;
			num_update_q <= sbim_pkg::NUM_UPDATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sbim_pkg::CFG_NUM_SUBSCR: num_subscr_q <= cfg_data[NS_W-1:0];
				sbim_pkg::CFG_NUM_UPDATE: num_update_q <= cfg_data[NU_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			id_s1 <= endpoint_id;
			lower_s1 <= is_lower;
			start_s1 <= pass_start;
			first_s1 <= first_dimension;
		end
	end

	// set and counter logic
	always_comb begin
		if (num_subscr_q == '0) begin
			ns_e = NS_W'(1);
		end else if (int'(num_subscr_q) > MAX_SUBSCR) begin
			ns_e = NS_W'(MAX_SUBSCR);
		end else begin
			ns_e = num_subscr_q;
		end
		if (num_update_q == '0) begin
			nu_e = NU_W'(1);
		end else if (int'(num_update_q) > MAX_UPDATE) begin
			nu_e = NU_W'(MAX_UPDATE);
		end else begin
			nu_e = num_update_q;
		end
		mask = ~({SET_W{1'b1}} << ns_e);

		if (start_s1) begin
			bef_e = '0;
			aft_e = '1;
			cnt_e = {nu_e, 1'b0};
		end else begin
			bef_e = before_q;
			aft_e = after_q;
			cnt_e = left_q;
		end

		bef_n = bef_e;
		aft_n = aft_e;
		cnt_n = cnt_e;
		snap_we = 1'b0;
		upper_hit = 1'b0;
		u = id_s1 - ID_W'(ns_e);
		addr_s1 = AW'(u);

		if (cnt_e != '0) begin
			if (id_s1 < ID_W'(ns_e)) begin
				if (lower_s1) begin
					aft_n = aft_e & ~(SET_W'(1) << id_s1[5:0]);
				end else begin
					bef_n = bef_e | (SET_W'(1) << id_s1[5:0]);
				end
			end else if (u < ID_W'(nu_e)) begin
				cnt_n = cnt_e - CNT_W'(1);
				snap_we = lower_s1;
				upper_hit = !lower_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			before_q <= '0;
			after_q <= '1;
			left_q <= '0;
		end else if (adv && valid_s1) begin
			before_q <= bef_n;
			after_q <= aft_n;
			left_q <= cnt_n;
		end
	end

	sbim_row_mem #(
		.DEPTH(MAX_UPDATE),
		.AW(AW)
	) u_snap_mem (
		.clk(clk),
		.we(adv && valid_s1 && snap_we),
		.waddr(addr_s1),
		.wdata(bef_e),
		.re(adv),
		.raddr(addr_s1),
		.rdata(snap_rd)
	);

	sbim_row_mem #(
		.DEPTH(MAX_UPDATE),
		.AW(AW)
	) u_acc_mem (
		.clk(clk),
		.we(adv && res_s2),
		.waddr(addr_s2),
		.wdata(row_s2),
		.re(adv),
		.raddr(addr_s1),
		.rdata(acc_rd)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
		end else if (adv) begin
			res_s2 <= valid_s1 && upper_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s2 <= addr_s1;
			uidx_s2 <= u[UIDX_W-1:0];
			first_s2 <= first_s1;
			open_s2 <= ~aft_e & mask;
			fwd_s2 <= res_s2 && (addr_s2 == addr_s1);
			wr_row_q <= row_s2;
		end
	end

	// row written to the same entry at the edge of the read bypasses the memory
	assign acc_val = fwd_s2 ? wr_row_q : acc_rd;
	assign row_s2 = first_s2 ? (open_s2 & ~snap_rd) : (open_s2 & ~snap_rd & acc_val);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_s2) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_s2) begin
			out_uidx_q <= uidx_s2;
			out_row_q <= row_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign update_index = out_uidx_q;
	assign match_row = out_row_q;

endmodule

### tb/sv/tb_sort_based_interest_matching_unit.sv
// testbench for the sort-based interest matching unit, checked against a row predictor
module tb_sort_based_interest_matching_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_W = sbim_pkg::ID_W;
	localparam int NS_W = sbim_pkg::NS_W;
	localparam int NU_W = sbim_pkg::NU_W;
	localparam int SET_W = sbim_pkg::SET_W;
	localparam int UIDX_W = sbim_pkg::UIDX_W;
	localparam int CFG_IDX_W = sbim_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = sbim_pkg::CFG_DATA_W;
	localparam int MAX_SUBSCR_DEF = sbim_pkg::MAX_SUBSCR_DEF;
	localparam int MAX_UPDATE_DEF = sbim_pkg::MAX_UPDATE_DEF;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int RANDOM_ITEMS = 300;

	typedef struct packed {
		logic [UIDX_W-1:0] uidx;
		logic [SET_W-1:0]  row;
	} match_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [ID_W-1:0]       endpoint_id;
	logic                  is_lower;
	logic                  pass_start;
	logic                  first_dimension;
	logic                  out_valid;
	logic                  out_stall;
	logic [UIDX_W-1:0]     update_index;
	logic [SET_W-1:0]      match_row;

	// predictor state
	logic [NS_W-1:0]  reg_ns;
	logic [NU_W-1:0]  reg_nu;
	logic [SET_W-1:0] before_subs;
	logic [SET_W-1:0] after_subs;
	logic [SET_W-1:0] snap_mem [MAX_UPDATE_DEF];
	logic [SET_W-1:0] row_mem [MAX_UPDATE_DEF];
	bit               snap_valid [MAX_UPDATE_DEF];
	bit               row_valid [MAX_UPDATE_DEF];
	int               endpoints_left;
	match_t           pending_rows [$];
	match_t           want_row;

	bit gaps_on;
	int burst_left;
	int stall_pct;
	bit hold_go;
	int items_sent;
	int errors;
	int quiet_cycles;

	sort_based_interest_matching_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.endpoint_id     (endpoint_id),
		.is_lower        (is_lower),
		.pass_start      (pass_start),
		.first_dimension (first_dimension),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.update_index    (update_index),
		.match_row       (match_row)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int subscr_count();
		if (reg_ns == 0) return 1;
		if (reg_ns > MAX_SUBSCR_DEF) return MAX_SUBSCR_DEF;
		return int'(reg_ns);
	endfunction

	function automatic int update_count();
		if (reg_nu == 0) return 1;
		if (reg_nu > MAX_UPDATE_DEF) return MAX_UPDATE_DEF;
		return int'(reg_nu);
	endfunction

	// update slot that an endpoint would count against, or -1
	function automatic int update_slot(logic [ID_W-1:0] id, bit start);
		int left;
		int u;
		left = start ? 2 * update_count() : endpoints_left;
		if (left == 0 || id < subscr_count()) return -1;
		u = int'(id) - subscr_count();
		return (u >= update_count()) ? -1 : u;
	endfunction

	task automatic match_endpoint(logic [ID_W-1:0] id, bit lower, bit start, bit first);
		int ns;
		int nu;
		int u;
		logic [SET_W-1:0] mask;
		logic [SET_W-1:0] row;
		ns = subscr_count();
		nu = update_count();
		if (start) begin
			before_subs = '0;
			after_subs = '1;
			endpoints_left = 2 * nu;
		end
		if (endpoints_left == 0) return;
		if (id < ns) begin
			if (lower) after_subs[id[5:0]] = 1'b0;
			else before_subs[id[5:0]] = 1'b1;
			return;
		end
		u = int'(id) - ns;
		if (u >= nu) return;
		endpoints_left--;
		if (lower) begin
			snap_mem[u] = before_subs;
			snap_valid[u] = 1'b1;
			return;
		end
		mask = (ns >= SET_W) ? '1 : ((64'd1 << ns) - 64'd1);
		row = ~(snap_mem[u] | after_subs) & mask;
		if (!first) row &= row_mem[u];
		row_mem[u] = row;
		row_valid[u] = 1'b1;
		pending_rows.push_back('{uidx: u[UIDX_W-1:0], row: row});
	endtask

	task automatic send_endpoint(logic [ID_W-1:0] id, bit lower, bit start, bit first);
		int u;
		u = update_slot(id, start);
		// never read a row entry that was never written
		if (u >= 0 && !lower && (!snap_valid[u] || (!first && !row_valid[u]))) lower = 1'b1;
		@(negedge clk);
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		endpoint_id <= id;
		is_lower <= lower;
		pass_start <= start;
		first_dimension <= first;
		do @(posedge clk); while (in_stall);
		match_endpoint(id, lower, start, first);
		items_sent++;
	endtask

	task automatic send_noise();
		send_endpoint(ID_W'($urandom_range(0, 319)), 1'($urandom_range(0, 1)),
			$urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == sbim_pkg::CFG_NUM_SUBSCR) reg_ns = data[NS_W-1:0];
		else reg_nu = data[NU_W-1:0];
	endtask

	// one sorted dimension pass over all subscriptions and the first n_upd updates, with random noise and drops
	task automatic run_pass(bit first, int n_upd, int noise_pct, int drop_pct);
		longint keys [$];
		int n_ext;
		int span;
		int lo;
		bit started;
		n_ext = subscr_count() + n_upd;
		span = 2 * n_ext + 2;
		for (int e = 0; e < n_ext; e++) begin
			lo = $urandom_range(0, span);
			keys.push_back((longint'(lo) << 20) | (longint'($urandom_range(0, 1023)) << 9)
				| longint'(e));
			keys.push_back((longint'(lo + $urandom_range(0, span / 2)) << 20) | (longint'(1) << 19)
				| (longint'($urandom_range(0, 1023)) << 9) | longint'(e));
		end
		keys.sort();
		started = 1'b0;
		foreach (keys[i]) begin
			if ($urandom_range(0, 99) < noise_pct) send_noise();
			if (started && $urandom_range(0, 99) < drop_pct) continue;
			send_endpoint(keys[i][ID_W-1:0], !keys[i][19], !started, first);
			started = 1'b1;
		end
	endtask

	task automatic test_before_first_pass();
		send_endpoint(9'd0, 1'b1, 1'b0, 1'b1);
		send_endpoint(9'd319, 1'b0, 1'b0, 1'b0);
		send_endpoint(9'd256, 1'b0, 1'b0, 1'b1);
		// reset sizes, partial pass touching the last update slot
		send_endpoint(9'd5, 1'b1, 1'b1, 1'b1);
		send_endpoint(9'd64, 1'b1, 1'b0, 1'b1);
		send_endpoint(9'd319, 1'b1, 1'b0, 1'b1);
		send_endpoint(9'd319, 1'b0, 1'b0, 1'b1);
	endtask

	task automatic test_two_dimensions();
		write_reg(sbim_pkg::CFG_NUM_SUBSCR, 9'd2);
		write_reg(sbim_pkg::CFG_NUM_UPDATE, 9'd2);
		send_endpoint(9'd0, 1'b1, 1'b1, 1'b1);
		send_endpoint(9'd2, 1'b1, 1'b0, 1'b1);
		send_endpoint(9'd0, 1'b0, 1'b0, 1'b1);
		send_endpoint(9'd1, 1'b1, 1'b0, 1'b1);
		send_endpoint(9'd2, 1'b0, 1'b0, 1'b1);
		send_endpoint(9'd1, 1'b0, 1'b0, 1'b1);
		send_endpoint(9'd3, 1'b1, 1'b0, 1'b1);
		send_endpoint(9'd3, 1'b0, 1'b0, 1'b1);
		// pass complete, these are dropped
		send_endpoint(9'd0, 1'b1, 1'b0, 1'b1);
		send_endpoint(9'd3, 1'b0, 1'b0, 1'b1);
		// second dimension, starting on an out of range update
		send_endpoint(9'd4, 1'b1, 1'b1, 1'b0);
		send_endpoint(9'd2, 1'b1, 1'b0, 1'b0);
		send_endpoint(9'd1, 1'b1, 1'b0, 1'b0);
		send_endpoint(9'd2, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic test_size_extremes();
		write_reg(sbim_pkg::CFG_NUM_SUBSCR, 9'd0);
		write_reg(sbim_pkg::CFG_NUM_UPDATE, 9'd0);
		send_endpoint(9'd0, 1'b1, 1'b1, 1'b1);
		send_endpoint(9'd1, 1'b1, 1'b0, 1'b1);
		send_endpoint(9'd1, 1'b0, 1'b0, 1'b1);
		write_reg(sbim_pkg::CFG_NUM_SUBSCR, 9'h1FF);
		write_reg(sbim_pkg::CFG_NUM_UPDATE, 9'h1FF);
		send_endpoint(9'd63, 1'b1, 1'b1, 1'b1);
		send_endpoint(9'd319, 1'b1, 1'b0, 1'b1);
		send_endpoint(9'd319, 1'b0, 1'b0, 1'b1);
	endtask

	task automatic test_backpressure();
		write_reg(sbim_pkg::CFG_NUM_SUBSCR, 9'd4);
		write_reg(sbim_pkg::CFG_NUM_UPDATE, 9'd8);
		gaps_on = 1'b0;
		stall_pct = 0;
		hold_go = 1'b1;
		run_pass(1'b1, 8, 0, 0);
		run_pass(1'b0, 8, 0, 0);
		wait_idle();
		gaps_on = 1'b1;
		stall_pct = 50;
		run_pass(1'b0, 8, 0, 0);
	endtask

	task automatic test_random_passes();
		int stop_at;
		int n_upd;
		int passes;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			gaps_on = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 2))
				0: begin
					stall_pct = 0;
				end
				1: begin
					stall_pct = 25;
				end
				default: begin
					stall_pct = 60;
				end
			endcase
			write_reg(sbim_pkg::CFG_NUM_SUBSCR, CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
				$urandom_range(0, 511) : $urandom_range(1, 12)));
			write_reg(sbim_pkg::CFG_NUM_UPDATE, CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
				$urandom_range(0, 511) : $urandom_range(1, 6)));
			n_upd = $urandom_range(1, 6);
			if (n_upd > update_count()) n_upd = update_count();
			passes = $urandom_range(2, 4);
			for (int p = 0; p < passes; p++) begin
				run_pass(p == 0, n_upd, 10, 3);
				if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) send_noise();
			end
		end
	endtask

	// receiver stall pattern, with a long hold on request
	initial begin
		int seg_left;
		int hold_left;
		bit hold_done;
		out_stall = 1'b0;
		seg_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (seg_left > 0) begin
				seg_left--;
			end else begin
				seg_left = $urandom_range(0, 7);
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rows.size() == 0) begin
				$display("%0t unexpected transaction: expected none, actual index %0d row %h",
					$time, update_index, match_row);
				errors++;
			end else begin
				want_row = pending_rows.pop_front();
				if (update_index !== want_row.uidx) begin
					$display("%0t update_index mismatch: expected %0d actual %0d",
						$time, want_row.uidx, update_index);
					errors++;
				end
				if (match_row !== want_row.row) begin
					$display("%0t match_row mismatch: expected %h actual %h",
						$time, want_row.row, match_row);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sbim_pkg::CFG_NUM_SUBSCR;
		cfg_data = '0;
		in_valid = 1'b0;
		endpoint_id = '0;
		is_lower = 1'b0;
		pass_start = 1'b0;
		first_dimension = 1'b0;
		reg_ns = sbim_pkg::NUM_SUBSCR_RST;
		reg_nu = sbim_pkg::NUM_UPDATE_RST;
		before_subs = '0;
		after_subs = '1;
		endpoints_left = 0;
		gaps_on = 1'b1;
		burst_left = 0;
		stall_pct = 30;
		hold_go = 1'b0;
		items_sent = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_before_first_pass();
		test_two_dimensions();
		test_size_extremes();
		test_backpressure();
		test_random_passes();
		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
